>>> sv/cesd_pkg.sv
// Shared types, codes and helpers for the escape-sequence decoder.
// No dependencies; every other file but cesd_if imports this package.
package cesd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [2:0] MODE_TEXT = 3'd0;
  localparam logic [2:0] MODE_ESC  = 3'd1;
  localparam logic [2:0] MODE_CTRL = 3'd2;
  localparam logic [2:0] MODE_HEX0 = 3'd3;
  localparam logic [2:0] MODE_HEX  = 3'd4;
  localparam logic [2:0] MODE_OCT  = 3'd5;
  localparam logic [2:0] MODE_DROP = 3'd6;

  localparam logic [7:0] CTRL_LO = 8'd64;
  localparam logic [7:0] CTRL_HI = 8'd90;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       last;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } cmd_t;

  function automatic res_t mk_res(logic [7:0] b, logic bad, logic last);
    res_t r;
    r.data = bad ? 8'd0 : b;
    r.bad  = bad;
    r.last = last;
    return r;
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= "0" && c <= "9") v = {1'b1, 4'(c - 8'h30)};
    else if (c >= "a" && c <= "f") v = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") v = {1'b1, 4'(c - 8'h37)};
    return v;
  endfunction

endpackage

>>> sv/cesd_if.sv
// Handshake channels for raw string bytes and decoded bytes.
// Depends on nothing.
interface cesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface cesd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       bad_escape;
  logic       out_last;
  modport source (output valid, output out_byte, output bad_escape, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input bad_escape, input out_last,
                output ready);
endinterface

>>> sv/cesd_front.sv
// Front part: accepts raw bytes, tracks escape state, builds result commands.
// Depends on cesd_pkg and cesd_in_if.
module cesd_front import cesd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  cesd_in_if.sink    raw,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  logic       dollar_en;
  logic [2:0] mode, mode_next;
  logic [7:0] acc, acc_next;
  logic       take;

  assign raw.ready = !q_full;
  assign take      = raw.valid && raw.ready;

  always_comb begin
    logic [7:0] c;
    logic       last;
    logic [1:0] n;
    logic [4:0] hd;
    res_t       slot [2];
    c         = raw.in_byte;
    last      = raw.in_last;
    n         = 2'd0;
    hd        = hex_digit(c);
    slot[0]   = '0;
    slot[1]   = '0;
    mode_next = mode;
    acc_next  = acc;

    case (mode)
      MODE_ESC: begin
        mode_next = MODE_TEXT;
        case (c)
          "\\", "\"", "'": begin slot[n[0]] = mk_res(c, 1'b0, last); n = n + 2'd1; end
          "n": begin slot[n[0]] = mk_res(8'h0a, 1'b0, last); n = n + 2'd1; end
          "r": begin slot[n[0]] = mk_res(8'h0d, 1'b0, last); n = n + 2'd1; end
          "t": begin slot[n[0]] = mk_res(8'h09, 1'b0, last); n = n + 2'd1; end
          "f": begin slot[n[0]] = mk_res(8'h0c, 1'b0, last); n = n + 2'd1; end
          "b": begin slot[n[0]] = mk_res(8'h08, 1'b0, last); n = n + 2'd1; end
          "a": begin slot[n[0]] = mk_res(8'h07, 1'b0, last); n = n + 2'd1; end
          "e": begin slot[n[0]] = mk_res(8'h1b, 1'b0, last); n = n + 2'd1; end
          "$": begin
            if (dollar_en) begin
              slot[0] = mk_res("$", 1'b0, 1'b0);
              slot[1] = mk_res("$", 1'b0, last);
              n = 2'd2;
            end else begin
              slot[0] = mk_res(8'd0, 1'b1, last);
              n = 2'd1;
              mode_next = last ? MODE_TEXT : MODE_DROP;
            end
          end
          "c", "x": begin
            if (last) begin
              slot[0] = mk_res(8'd0, 1'b1, 1'b1);
              n = 2'd1;
            end else begin
              mode_next = (c == "c") ? MODE_CTRL : MODE_HEX0;
            end
          end
          "0": begin
            acc_next = 8'd0;
            if (last) begin
              slot[0] = mk_res(8'd0, 1'b0, 1'b1);
              n = 2'd1;
            end else begin
              mode_next = MODE_OCT;
            end
          end
          default: begin
            slot[0] = mk_res(8'd0, 1'b1, last);
            n = 2'd1;
            mode_next = last ? MODE_TEXT : MODE_DROP;
          end
        endcase
      end
      MODE_CTRL: begin
        if (c >= CTRL_LO && c <= CTRL_HI) begin
          slot[0] = mk_res(c - CTRL_LO, 1'b0, last);
          mode_next = MODE_TEXT;
        end else begin
          slot[0] = mk_res(8'd0, 1'b1, last);
          mode_next = last ? MODE_TEXT : MODE_DROP;
        end
        n = 2'd1;
      end
      MODE_HEX0: begin
        if (hd[4]) begin
          acc_next = {4'd0, hd[3:0]};
          mode_next = MODE_HEX;
          if (last) begin
            slot[0] = mk_res(acc_next, 1'b0, 1'b1);
            n = 2'd1;
          end
        end else begin
          slot[0] = mk_res(8'd0, 1'b1, last);
          n = 2'd1;
          mode_next = last ? MODE_TEXT : MODE_DROP;
        end
      end
      MODE_HEX, MODE_OCT: begin
        if ((mode == MODE_HEX) ? hd[4] : (c >= "0" && c <= "7")) begin
          acc_next = (mode == MODE_HEX) ? {acc[3:0], hd[3:0]} : {acc[4:0], c[2:0]};
          if (last) begin
            slot[0] = mk_res(acc_next, 1'b0, 1'b1);
            n = 2'd1;
          end
        end else begin
          slot[0] = mk_res(acc, 1'b0, 1'b0);
          n = 2'd1;
          mode_next = MODE_TEXT;
          if (c == "\\") begin
            if (last) begin
              slot[1] = mk_res(8'd0, 1'b1, 1'b1);
              n = 2'd2;
            end else begin
              mode_next = MODE_ESC;
            end
          end else begin
            slot[1] = mk_res(c, 1'b0, last);
            n = 2'd2;
          end
        end
      end
      MODE_DROP: begin
        if (last) begin
          slot[0] = mk_res(8'd0, 1'b1, 1'b1);
          n = 2'd1;
        end
      end
      default: begin
        if (c == "\\") begin
          if (last) begin
            slot[0] = mk_res(8'd0, 1'b1, 1'b1);
            n = 2'd1;
          end else begin
            mode_next = MODE_ESC;
          end
        end else begin
          slot[0] = mk_res(c, 1'b0, last);
          n = 2'd1;
        end
      end
    endcase

    if (last) begin
      mode_next = MODE_TEXT;
      acc_next  = 8'd0;
    end

    cmd.two = n[1];
    cmd.r0  = slot[0];
    cmd.r1  = slot[1];
    push    = take && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dollar_en <= 1'b0;
      mode      <= MODE_TEXT;
      acc       <= 8'd0;
    end else begin
      if (cfg_we) dollar_en <= cfg_wdata;
      if (take) begin
        mode <= mode_next;
        acc  <= acc_next;
      end
    end
  end

endmodule

>>> sv/cesd_queue.sv
// Short command queue between the front and back parts.
// Depends on cesd_pkg.
module cesd_queue import cesd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic full,
  output logic empty
);

  cmd_t         mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> sv/cesd_back.sv
// Back part: unpacks queued commands into result items behind an output register.
// Depends on cesd_pkg and cesd_out_if.
module cesd_back import cesd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       pop,
  cesd_out_if.source dec
);

  logic sel;
  logic load;
  res_t cur;

  assign load = !q_empty && (!dec.valid || dec.ready);
  assign cur  = sel ? head.r1 : head.r0;
  assign pop  = load && (sel || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 1'b0;
      dec.valid <= 1'b0;
    end else begin
      if (load) begin
        sel       <= !pop;
        dec.valid <= 1'b1;
      end else if (dec.ready) begin
        dec.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec.out_byte   <= cur.data;
      dec.bad_escape <= cur.bad;
      dec.out_last   <= cur.last;
    end
  end

endmodule

>>> sv/c_escape_sequence_decoder_top.sv
// Top level of the C string escape decoder: front, command queue, back.
// Depends on cesd_pkg, cesd_if, cesd_front, cesd_queue, cesd_back.
//
//   channel  dir  payload                           handshake
//   raw      in   in_byte[7:0], in_last             valid/ready
//   dec      out  out_byte[7:0], bad_escape, out_last  valid/ready
//   cfg      in   cfg_wdata (dollar escape enable)  cfg_we
//
// One raw byte is accepted per cycle while the four-entry command queue has room.
// Each byte yields zero, one or two results; the back end sends one result per
// cycle while the output is ready, so a byte with two results takes two transfers.
// Each result passes through the command queue and then the output register.
// Reset clears the escape state, the dollar enable, the queue and the output valid.
module c_escape_sequence_decoder_top import cesd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  cesd_in_if.sink    raw,
  cesd_out_if.source dec
);

  logic push, pop, q_full, q_empty;
  cmd_t wcmd, head;

  cesd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .raw       (raw),
    .q_full    (q_full),
    .push      (push),
    .cmd       (wcmd)
  );

  cesd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wcmd),
    .pop   (pop),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  cesd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .dec     (dec)
  );

endmodule
